@@ rtl/core/lattice_upset_downset_marker_assert.svh @@
// assertion helpers for the marker rtl
`ifndef LATTICE_UPSET_DOWNSET_MARKER_ASSERT_SVH
`define LATTICE_UPSET_DOWNSET_MARKER_ASSERT_SVH

// same-cycle implication
`define LUM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LUM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/lum_pkg.sv @@
package lum_pkg;

  localparam int MAX_BITS_DEF  = 10;
  localparam int WORD_BITS     = 32;
  localparam int LANE_BITS     = 5;
  localparam int CFG_W         = 4;
  localparam int CMD_W         = 2;
  localparam int MASK_W        = 10;
  localparam int COUNT_W       = 11;
  localparam int PCNT_W        = 6;
  localparam int IN_DATA_W     = 16;
  localparam int OUT_DATA_W    = 16;
  localparam logic [CFG_W-1:0] LATTICE_RESET = 4'd10;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_MARK  = 2'd1,
    CMD_UP    = 2'd2,
    CMD_DOWN  = 2'd3
  } cmd_t;

  // was_marked sits in bit 0
  typedef struct packed {
    logic               all_marked;
    logic [COUNT_W-1:0] marked_count;
    logic               was_marked;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

  function automatic int addr_w(int max_bits);
    return (max_bits > LANE_BITS) ? (max_bits - LANE_BITS) : 1;
  endfunction

  // size register value clamped to 1 .. max_bits
  function automatic logic [4:0] clamp_bits(logic [CFG_W-1:0] v, int max_bits);
    logic [4:0] r;
    if (v == '0) begin
      r = 5'd1;
    end else if (int'(v) > max_bits) begin
      r = 5'(max_bits);
    end else begin
      r = 5'(v);
    end
    return r;
  endfunction

  // nibble counts, then an eight-way sum
  function automatic logic [PCNT_W-1:0] popcount(logic [WORD_BITS-1:0] v);
    logic [2:0]        q [WORD_BITS/4];
    logic [PCNT_W-1:0] sum;
    for (int i = 0; i < WORD_BITS/4; i++) begin
      q[i] = 3'(v[4*i]) + 3'(v[4*i+1]) + 3'(v[4*i+2]) + 3'(v[4*i+3]);
    end
    sum = '0;
    for (int i = 0; i < WORD_BITS/4; i++) begin
      sum = sum + PCNT_W'(q[i]);
    end
    return sum;
  endfunction

endpackage

@@ rtl/core/lum_store.sv @@
module lum_store #(
  parameter int ADDR_W = 5
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [ADDR_W-1:0]             waddr,
  input  logic [lum_pkg::WORD_BITS-1:0] wdata,
  input  logic [ADDR_W-1:0]             raddr,
  output logic [lum_pkg::WORD_BITS-1:0] rdata
);

  localparam int DEPTH = 2 ** ADDR_W;

  logic [lum_pkg::WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/lum_word_unit.sv @@
module lum_word_unit #(
  parameter int MAX_BITS = lum_pkg::MAX_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lum_pkg::cmd_t                 cmd,
  input  logic [lum_pkg::addr_w(MAX_BITS)+lum_pkg::LANE_BITS-1:0] m_x,
  input  logic [MAX_BITS:0]             size,
  input  logic                          word_valid,
  input  logic [lum_pkg::addr_w(MAX_BITS)-1:0] word_addr,
  input  logic [lum_pkg::WORD_BITS-1:0] old_word,
  output logic [lum_pkg::WORD_BITS-1:0] new_word,
  output logic                          add_valid,
  output logic [lum_pkg::PCNT_W-1:0]    add_cnt
);

  localparam int ADDR_W = lum_pkg::addr_w(MAX_BITS);
  localparam int SX_W   = ADDR_W + lum_pkg::LANE_BITS;

  logic [lum_pkg::WORD_BITS-1:0] hit;
  logic [lum_pkg::WORD_BITS-1:0] added;

  // per-lane membership test of state {word_addr, lane}
  always_comb begin
    logic [SX_W-1:0] s;
    hit = '0;
    for (int j = 0; j < lum_pkg::WORD_BITS; j++) begin
      s = {word_addr, lum_pkg::LANE_BITS'(j)};
      case (cmd)
        lum_pkg::CMD_MARK: hit[j] = (s == m_x);
        lum_pkg::CMD_UP:   hit[j] = ((s & m_x) == m_x) &&
                                    ({1'b0, s} < (SX_W+1)'(size));
        lum_pkg::CMD_DOWN: hit[j] = ((s & ~m_x) == '0);
        default:           hit[j] = 1'b0;
      endcase
    end
  end

  assign new_word = old_word | hit;
  assign added    = hit & ~old_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      add_valid <= 1'b0;
    end else begin
      add_valid <= word_valid;
    end
    add_cnt <= lum_pkg::popcount(added);
  end

endmodule

@@ rtl/core/lum_seq.sv @@
`include "lattice_upset_downset_marker_assert.svh"

module lum_seq #(
  parameter int MAX_BITS = lum_pkg::MAX_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lum_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  lum_pkg::cmd_t                 in_cmd,
  input  logic [lum_pkg::MASK_W-1:0]    in_mask,
  output logic [lum_pkg::addr_w(MAX_BITS)-1:0] rd_addr,
  input  logic [lum_pkg::WORD_BITS-1:0] rd_data,
  output logic                          wr_en,
  output logic [lum_pkg::addr_w(MAX_BITS)-1:0] wr_addr,
  output logic [lum_pkg::WORD_BITS-1:0] wr_data,
  output lum_pkg::cmd_t                 cmd,
  output logic [lum_pkg::addr_w(MAX_BITS)+lum_pkg::LANE_BITS-1:0] m_x,
  output logic [MAX_BITS:0]             size,
  output logic                          p_valid,
  output logic [lum_pkg::addr_w(MAX_BITS)-1:0] p_addr,
  input  logic [lum_pkg::WORD_BITS-1:0] new_word,
  input  logic                          add_valid,
  input  logic [lum_pkg::PCNT_W-1:0]    add_cnt,
  output logic                          res_valid,
  output lum_pkg::result_t              res,
  input  logic                          res_taken
);

  localparam int ADDR_W = lum_pkg::addr_w(MAX_BITS);
  localparam int SX_W   = ADDR_W + lum_pkg::LANE_BITS;
  localparam int TOT_W  = MAX_BITS + 1;
  localparam int N_W    = $clog2(MAX_BITS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_WAS,
    S_CLEAR,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t                         state;
  logic [N_W-1:0]                 n_act;
  logic [ADDR_W-1:0]              wc;
  logic [ADDR_W-1:0]              end_word;
  logic                           reply;
  logic                           was_r;
  logic [TOT_W-1:0]               total;

  logic [SX_W-1:0]                m_in;
  logic [ADDR_W-1:0]              m_word;
  logic [lum_pkg::LANE_BITS-1:0]  m_lane;
  logic [ADDR_W-1:0]              last_word;
  logic                           cfg_fire;

  assign size      = TOT_W'(1) << n_act;
  assign m_in      = SX_W'(in_mask) & SX_W'(size - 1'b1);
  assign m_word    = m_x[SX_W-1:lum_pkg::LANE_BITS];
  assign m_lane    = m_x[lum_pkg::LANE_BITS-1:0];
  assign last_word = (int'(n_act) > lum_pkg::LANE_BITS) ?
                     ADDR_W'((size >> lum_pkg::LANE_BITS) - 1'b1) : '0;

  assign cfg_ready = (state == S_IDLE) || ((state == S_CLEAR) && !reply);
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_ready  = (state == S_IDLE) && !cfg_valid;

  assign rd_addr = (state == S_SCAN) ? wc : m_word;
  assign wr_en   = (state == S_CLEAR) || p_valid;
  assign wr_addr = p_valid ? p_addr : wc;
  assign wr_data = p_valid ? new_word : '0;

  assign res_valid        = (state == S_DONE);
  assign res.was_marked   = was_r;
  assign res.marked_count = lum_pkg::COUNT_W'(total);
  assign res.all_marked   = (total == size);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      n_act   <= N_W'(lum_pkg::clamp_bits(lum_pkg::LATTICE_RESET, MAX_BITS));
      wc      <= '0;
      reply   <= 1'b0;
      total   <= '0;
      p_valid <= 1'b0;
    end else begin
      p_valid <= (state == S_SCAN);
      p_addr  <= wc;
      if (add_valid) begin
        total <= total + TOT_W'(add_cnt);
      end
      if (cfg_fire) begin
        n_act <= N_W'(lum_pkg::clamp_bits(cfg_data, MAX_BITS));
        state <= S_CLEAR;
        wc    <= '0;
        reply <= 1'b0;
        total <= '0;
      end else begin
        case (state)
          S_IDLE: begin
            if (in_valid) begin
              cmd   <= in_cmd;
              m_x   <= m_in;
              state <= S_PROBE;
            end
          end
          S_PROBE: begin
            state <= S_WAS;
          end
          S_WAS: begin
            was_r <= rd_data[m_lane];
            case (cmd)
              lum_pkg::CMD_CLEAR: begin
                wc    <= '0;
                reply <= 1'b1;
                total <= '0;
                state <= S_CLEAR;
              end
              lum_pkg::CMD_MARK: begin
                wc       <= m_word;
                end_word <= m_word;
                state    <= S_SCAN;
              end
              default: begin
                wc       <= '0;
                end_word <= last_word;
                state    <= S_SCAN;
              end
            endcase
          end
          S_CLEAR: begin
            wc <= wc + 1'b1;
            if (wc == '1) begin
              state <= reply ? S_DONE : S_IDLE;
            end
          end
          S_SCAN: begin
            wc <= wc + 1'b1;
            if (wc == end_word) begin
              state <= S_DRAIN;
            end
          end
          S_DRAIN: begin
            if (!p_valid) begin
              state <= S_DONE;
            end
          end
          S_DONE: begin
            if (res_taken) begin
              state <= S_IDLE;
            end
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

  `LUM_ASSERT_NOW(a_total_bound, clk, rst, 1'b1, total <= size, "mark total above lattice size")
  `LUM_ASSERT_NOW(a_clear_zero, clk, rst, state == S_CLEAR, total == '0, "total not zero in clear")
  `LUM_ASSERT_NOW(a_pipe_state, clk, rst, p_valid, state == S_SCAN || state == S_DRAIN, "stray word")
  `LUM_ASSERT_NEXT(a_accept_probe, clk, rst, in_valid && in_ready, state == S_PROBE, "no probe")

endmodule

@@ rtl/core/lattice_upset_downset_marker.sv @@
// channel   | signals                           | payload
// ----------+-----------------------------------+------------------------------------------
// input     | s_tvalid s_tready s_tdata s_tuser | tuser: command; tdata: state_mask
// result    | m_tvalid m_tready m_tdata         | tdata: was_marked, marked_count, all_marked
// config    | cfg_valid cfg_ready cfg_data      | lattice_bits
//
// up or down marking: 2^(n-5) word read-modify-writes on the shared word unit (one per
//   cycle, n = active lattice bits, at least one)
// single mark: one word read-modify-write; clear: 2^(MAX_BITS-5) word writes
// reset and every config write sweep the store with s_tready low; config beats are
//   still taken during that sweep
// a finished result waits in the output register while the next beat is taken
module lattice_upset_downset_marker #(
  parameter int MAX_BITS = lum_pkg::MAX_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [lum_pkg::IN_DATA_W-1:0]    s_tdata,  // [9:0] state_mask
  input  logic [lum_pkg::CMD_W-1:0]        s_tuser,  // [1:0] command
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [lum_pkg::OUT_DATA_W-1:0]   m_tdata,  // [0] was_marked, [11:1] marked_count,
                                                     // [12] all_marked
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lum_pkg::CFG_W-1:0]        cfg_data
);

  localparam int ADDR_W = lum_pkg::addr_w(MAX_BITS);
  localparam int SX_W   = ADDR_W + lum_pkg::LANE_BITS;

  logic [ADDR_W-1:0]              rd_addr;
  logic [lum_pkg::WORD_BITS-1:0]  rd_data;
  logic                           wr_en;
  logic [ADDR_W-1:0]              wr_addr;
  logic [lum_pkg::WORD_BITS-1:0]  wr_data;
  lum_pkg::cmd_t                  cmd;
  logic [SX_W-1:0]                m_x;
  logic [MAX_BITS:0]              size;
  logic                           p_valid;
  logic [ADDR_W-1:0]              p_addr;
  logic [lum_pkg::WORD_BITS-1:0]  new_word;
  logic                           add_valid;
  logic [lum_pkg::PCNT_W-1:0]     add_cnt;
  logic                           res_valid;
  lum_pkg::result_t               res;
  logic                           res_taken;

  assign res_taken = res_valid && (!m_tvalid || m_tready);

  lum_store #(
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  lum_word_unit #(
    .MAX_BITS (MAX_BITS)
  ) u_word_unit (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .m_x        (m_x),
    .size       (size),
    .word_valid (p_valid),
    .word_addr  (p_addr),
    .old_word   (rd_data),
    .new_word   (new_word),
    .add_valid  (add_valid),
    .add_cnt    (add_cnt)
  );

  lum_seq #(
    .MAX_BITS (MAX_BITS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_cmd    (lum_pkg::cmd_t'(s_tuser)),
    .in_mask   (s_tdata[lum_pkg::MASK_W-1:0]),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .cmd       (cmd),
    .m_x       (m_x),
    .size      (size),
    .p_valid   (p_valid),
    .p_addr    (p_addr),
    .new_word  (new_word),
    .add_valid (add_valid),
    .add_cnt   (add_cnt),
    .res_valid (res_valid),
    .res       (res),
    .res_taken (res_taken)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (res_taken) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    if (res_taken) begin
      m_tdata <= lum_pkg::OUT_DATA_W'(res);
    end
  end

endmodule
